// ===== hdl/kth_largest_stream_select_macros.svh =====
// ----------------------------------------------------------------------------
// kth_largest_stream_select_macros
// Assertion shorthands shared by the k-th largest selector modules.
// ----------------------------------------------------------------------------
`ifndef KTH_LARGEST_STREAM_SELECT_MACROS_SVH
`define KTH_LARGEST_STREAM_SELECT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define KLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define KLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// Shared constants and controller/datapath interface types for the
// k-th largest stream selector.
// ----------------------------------------------------------------------------
package kls_pkg;

  localparam int MAX_K      = 16;
  localparam int VALUE_BITS = 32;
  localparam int RANK_W     = 5;
  localparam int COUNT_W    = $clog2(MAX_K + 1);
  localparam int KEFF_W     = (COUNT_W > RANK_W) ? COUNT_W : RANK_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_RANK_K = '0;

  // Commands from the controller to the sorted store.
  typedef struct packed {
    logic               fill;     // insert the item while the store is filling
    logic               replace;  // drop the smallest entry and insert the item
    logic               capture;  // load the result register from the new minimum
    logic [COUNT_W-1:0] count;    // number of valid entries before this item
  } kls_cmd_t;

  typedef struct packed {
    logic beats_min;  // the incoming value is above the smallest kept value
  } kls_status_t;

endpackage

// ===== hdl/kls_ctrl.sv =====
// ----------------------------------------------------------------------------
// kls_ctrl
// Controller: handshakes, fill/keep state machine, entry count and the
// result valid and too-few flags.
// ----------------------------------------------------------------------------
module kls_ctrl
  import kls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              too_few,
  input  logic              cfg_clear,
  input  logic [RANK_W-1:0] rank_k,
  input  kls_status_t       status,
  output kls_cmd_t          cmd
);

  typedef enum logic {
    S_FILL,
    S_KEEP
  } state_t;

  state_t             state_r;
  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r;
  logic               too_few_r;

  logic [KEFF_W-1:0]  rank_ext;
  logic [KEFF_W-1:0]  k_clamp;
  logic [COUNT_W-1:0] k_eff;
  logic [COUNT_W-1:0] count_inc;
  logic               accept;

  // A rank of zero acts as one, a rank above the store depth as the depth.
  always_comb begin
    rank_ext = KEFF_W'(rank_k);
    if (rank_ext == '0) begin
      k_clamp = KEFF_W'(1);
    end else if (rank_ext > KEFF_W'(MAX_K)) begin
      k_clamp = KEFF_W'(MAX_K);
    end else begin
      k_clamp = rank_ext;
    end
    k_eff = k_clamp[COUNT_W-1:0];
  end

  assign count_inc  = count_r + COUNT_W'(1);
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign too_few    = too_few_r;

  always_comb begin
    cmd.fill    = accept && (state_r == S_FILL);
    cmd.replace = accept && (state_r == S_KEEP) && status.beats_min;
    cmd.capture = accept && in_tlast;
    cmd.count   = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.capture) begin
        out_valid_r <= 1'b1;
        too_few_r   <= (state_r == S_FILL) && (count_inc < k_eff);
      end
      if (cfg_clear) begin
        state_r <= S_FILL;
        count_r <= '0;
      end else if (accept) begin
        if (in_tlast) begin
          state_r <= S_FILL;
          count_r <= '0;
        end else begin
          case (state_r)
            S_FILL: begin
              count_r <= count_inc;
              if (count_inc == k_eff) begin
                state_r <= S_KEEP;
              end
            end
            S_KEEP: begin
              count_r <= count_r;
            end
            default: begin
              state_r <= S_FILL;
              count_r <= '0;
            end
          endcase
        end
      end
    end
  end

`include "kth_largest_stream_select_macros.svh"

  `KLS_ASSERT_NOW(a_fill_below_rank, state_r == S_FILL, count_r < k_eff, "fill count reached rank")
  `KLS_ASSERT_NOW(a_keep_at_rank, state_r == S_KEEP, count_r == k_eff, "keep state off rank")
  `KLS_ASSERT_NEXT(a_last_restarts, cmd.capture, out_valid_r && (count_r == '0) && (state_r == S_FILL), "last item did not post result and restart")

endmodule

// ===== hdl/kls_datapath.sv =====
// ----------------------------------------------------------------------------
// kls_datapath
// Sorted store of the kept values (smallest in entry zero) and the result
// register.
// ----------------------------------------------------------------------------
module kls_datapath
  import kls_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  kls_cmd_t                     cmd,
  output kls_status_t                  status,
  output logic signed [VALUE_BITS-1:0] kth_value
);

  logic signed [VALUE_BITS-1:0] cell_r   [MAX_K];
  logic signed [VALUE_BITS-1:0] cell_nxt [MAX_K];
  logic signed [VALUE_BITS-1:0] cell_prv [MAX_K];
  logic signed [VALUE_BITS-1:0] cell_fol [MAX_K];
  logic signed [VALUE_BITS-1:0] kth_r;
  logic [MAX_K-1:0]             lt;
  logic [MAX_K-1:0]             lt_prv;
  logic [MAX_K-1:0]             lt_fol;

  // The store is kept in ascending order, so every valid entry below the
  // incoming value sits in one run starting at entry zero.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      lt[i] = (COUNT_W'(i) < cmd.count) && (cell_r[i] < in_value);
    end
  end

  always_comb begin
    lt_prv[0]   = 1'b1;
    cell_prv[0] = cell_r[0];
    for (int i = 1; i < MAX_K; i++) begin
      lt_prv[i]   = lt[i-1];
      cell_prv[i] = cell_r[i-1];
    end
    lt_fol[MAX_K-1]   = 1'b0;
    cell_fol[MAX_K-1] = cell_r[MAX_K-1];
    for (int i = 0; i < MAX_K - 1; i++) begin
      lt_fol[i]   = lt[i+1];
      cell_fol[i] = cell_r[i+1];
    end
  end

  // Fill inserts the value and shifts larger entries up; replace drops
  // entry zero and shifts smaller entries down to make room.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.fill) begin
        if (lt[i]) begin
          cell_nxt[i] = cell_r[i];
        end else if (lt_prv[i]) begin
          cell_nxt[i] = in_value;
        end else begin
          cell_nxt[i] = cell_prv[i];
        end
      end else if (cmd.replace) begin
        if (lt_fol[i]) begin
          cell_nxt[i] = cell_fol[i];
        end else if ((i == 0) || lt[i]) begin
          cell_nxt[i] = in_value;
        end else begin
          cell_nxt[i] = cell_r[i];
        end
      end
    end
  end

  assign status.beats_min = in_value > cell_r[0];
  assign kth_value        = kth_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_K; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (cmd.capture) begin
      kth_r <= cell_nxt[0];
    end
  end

`include "kth_largest_stream_select_macros.svh"

  `KLS_ASSERT_NOW(a_replace_beats_min, cmd.replace, in_value > cell_r[0], "replace without a larger value")
  `KLS_ASSERT_NEXT(a_min_never_drops, cmd.replace, cell_r[0] >= $past(cell_r[0]), "replace lowered the minimum")

endmodule

// ===== hdl/kth_largest_stream_select.sv =====
// A last item's result appears on out_tvalid the cycle after it is accepted.
// One item per cycle while in_tready is high; each accepted item updates the sorted store.
// Input stalls only while a result waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous): rank_k returns to 1, the kept count clears and no
// result is pending; stored values are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// kth_largest_stream_select
// Streams signed values and reports the k-th largest of each set on its
// last item, with a flag when the set held fewer than k values.
// ----------------------------------------------------------------------------
module kth_largest_stream_select
  import kls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [31:0] value
  input  logic [VALUE_BITS-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: [31:0] kth_value
  output logic [VALUE_BITS-1:0] out_tdata,
  // out_tuser: [0] too_few
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [RANK_W-1:0]            rank_k_r;
  logic                         cfg_write;
  logic                         rank_sel;
  kls_cmd_t                     cmd;
  kls_status_t                  status;
  logic signed [VALUE_BITS-1:0] kth_value;

  assign cfg_pready = 1'b1;
  assign rank_sel   = (cfg_paddr[CFG_ADDR_W-1:2] == REG_RANK_K);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r <= RANK_W'(1);
    end else if (cfg_write && rank_sel) begin
      rank_k_r <= cfg_pwdata[RANK_W-1:0];
    end
  end

  always_comb begin
    if (rank_sel) begin
      cfg_prdata = CFG_DATA_W'(rank_k_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  kls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .too_few    (out_tuser),
    .cfg_clear  (cfg_write && rank_sel),
    .rank_k     (rank_k_r),
    .status     (status),
    .cmd        (cmd)
  );

  kls_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  ($signed(in_tdata)),
    .cmd       (cmd),
    .status    (status),
    .kth_value (kth_value)
  );

  assign out_tdata = $unsigned(kth_value);

endmodule
